// File: design/kts_pkg.sv
`default_nettype none
package kts_pkg;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  key_index;
    logic [31:0] time_ticks;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
  } out_item_t;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] KIND_ROT   = 2'd0;
  localparam logic [1:0] KIND_SCALE = 2'd1;
  localparam logic [1:0] KIND_TRANS = 2'd2;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_BINDX = 2'd1;
  localparam logic [1:0] REG_BINDY = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SREQ, ST_SCMP, ST_PREQ, ST_PWAIT, ST_PCHK,
    ST_DIV, ST_LX, ST_LY, ST_MUL, ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: design/keyframe_track_sampler_unit.sv
// Sequence: a sample runs a binary search of 1 to log2(MAX_KEYS)+1 probes, reads the key pair,
// divides for the fraction, interpolates x and y, multiplies and outputs; the division is
// skipped when the fraction is clamped, and interpolation is too when one end key is used as is.
// Flow: a load is written at its transfer edge and the next item may follow at once;
// busy holds off the next item until the result strobe cycle. The receiver cannot stall.
// Reset (rst, synchronous, active high) clears control and config; key memory is not cleared.
`default_nettype none
module keyframe_track_sampler_unit #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire kts_pkg::in_item_t in_item,
  output logic                   result_valid,
  output kts_pkg::out_item_t     result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // Key memory: time, x and y packed in one word.
  logic [95:0] mem [MAX_KEYS];
  logic [95:0] rd;
  logic [AW-1:0] raddr;
  logic          wen;

  logic [1:0]  kind;
  logic signed [31:0] bind_x, bind_y;
  logic [6:0]  key_count;

  kts_pkg::state_t state, state_next;
  logic [31:0] t;
  logic [CW-1:0] lo, hi, n;
  logic [AW-1:0] li, ri;
  logic [95:0] lkey;
  logic        same;
  logic [31:0] rem;
  logic [31:0] den;
  logic [16:0] frac;
  logic [4:0]  cnt;
  logic signed [31:0] vx, vy;
  logic signed [63:0] prod;

  // Effective key count, clamped to [1, MAX_KEYS].
  always_comb begin
    if (key_count == 7'd0) begin
      n = CW'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n = CW'(MAX_KEYS);
    end else begin
      n = CW'(key_count);
    end
  end

  logic [CW-1:0] mid;
  assign mid = CW'((32'(lo) + 32'(hi)) >> 1);

  // Memory port.
  always_comb begin
    raddr = mid[AW-1:0];
    if (state == kts_pkg::ST_PREQ) begin
      raddr = li;
    end else if (state == kts_pkg::ST_PCHK || state == kts_pkg::ST_PWAIT) begin
      raddr = ri;
    end
  end
  assign wen = start && !busy && in_item.opcode == kts_pkg::OP_LOAD &&
               32'(in_item.key_index) < MAX_KEYS;
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[AW'(in_item.key_index)] <= {in_item.time_ticks, in_item.value_x,
                                      in_item.value_y};
    end
    rd <= mem[raddr];
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= kts_pkg::KIND_ROT;
      bind_x <= '0;
      bind_y <= '0;
      key_count <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kts_pkg::REG_KIND:  kind <= cfg_data[1:0];
        kts_pkg::REG_BINDX: bind_x <= cfg_data;
        kts_pkg::REG_BINDY: bind_y <= cfg_data;
        kts_pkg::REG_COUNT: key_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = state != kts_pkg::ST_IDLE;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      kts_pkg::ST_IDLE:
        if (start && in_item.opcode == kts_pkg::OP_SAMPLE) state_next = kts_pkg::ST_SREQ;
      kts_pkg::ST_SREQ:
        state_next = (lo < hi) ? kts_pkg::ST_SCMP : kts_pkg::ST_PREQ;
      kts_pkg::ST_SCMP:  state_next = kts_pkg::ST_SREQ;
      kts_pkg::ST_PREQ:  state_next = kts_pkg::ST_PWAIT;
      kts_pkg::ST_PWAIT: state_next = kts_pkg::ST_PCHK;
      kts_pkg::ST_PCHK: begin
        if (same || lkey[95:64] >= rd[95:64]) begin
          state_next = kts_pkg::ST_MUL;
        end else if (t <= lkey[95:64] || t >= rd[95:64]) begin
          state_next = kts_pkg::ST_LX;
        end else begin
          state_next = kts_pkg::ST_DIV;
        end
      end
      kts_pkg::ST_DIV:   if (cnt == 5'd15) state_next = kts_pkg::ST_LX;
      kts_pkg::ST_LX:    state_next = kts_pkg::ST_LY;
      kts_pkg::ST_LY:    state_next = kts_pkg::ST_MUL;
      kts_pkg::ST_MUL:   state_next = kts_pkg::ST_OUT;
      kts_pkg::ST_OUT:   state_next = kts_pkg::ST_IDLE;
      default:           state_next = kts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lerp terms: difference times fraction, floored shift.
  logic signed [32:0] dx;
  logic signed [50:0] pl;
  always_comb begin
    if (state == kts_pkg::ST_LX) begin
      dx = 33'(signed'(rd[63:32])) - 33'(signed'(lkey[63:32]));
    end else begin
      dx = 33'(signed'(rd[31:0])) - 33'(signed'(lkey[31:0]));
    end
    pl = 51'(dx) * 51'(signed'({1'b0, frac}));
  end

  // Datapath.
  logic [31:0] dt;
  logic [32:0] rem_sh;
  assign dt = t - lkey[95:64];
  assign rem_sh = {rem, 1'b0};
  always_ff @(posedge clk) begin
    unique case (state)
      kts_pkg::ST_IDLE: begin
        t <= in_item.time_ticks;
        lo <= '0;
        hi <= n;
      end
      kts_pkg::ST_SCMP: begin
        if (rd[95:64] < t) lo <= mid + CW'(1);
        else hi <= mid;
      end
      kts_pkg::ST_SREQ: begin
        if (!(lo < hi)) begin
          if (lo >= n) begin
            li <= AW'(n - CW'(1));
            ri <= AW'(n - CW'(1));
            same <= 1'b1;
          end else if (lo == '0) begin
            li <= '0;
            ri <= '0;
            same <= 1'b1;
          end else begin
            li <= AW'(lo - CW'(1));
            ri <= AW'(lo);
            same <= 1'b0;
          end
        end
      end
      kts_pkg::ST_PWAIT: lkey <= rd;
      kts_pkg::ST_PCHK: begin
        vx <= lkey[63:32];
        vy <= lkey[31:0];
        den <= rd[95:64] - lkey[95:64];
        cnt <= '0;
        rem <= dt;
        // Outside the pair the fraction is clamped to 0 or 1 and no division runs.
        frac <= (t >= rd[95:64]) ? 17'h10000 : 17'd0;
      end
      kts_pkg::ST_DIV: begin
        // Restoring division: one quotient bit per step, remainder stays below den.
        cnt <= cnt + 5'd1;
        if (rem_sh >= {1'b0, den}) begin
          frac <= {frac[15:0], 1'b1};
          rem <= rem_sh[31:0] - den;
        end else begin
          frac <= {frac[15:0], 1'b0};
          rem <= rem_sh[31:0];
        end
      end
      kts_pkg::ST_LX: vx <= 32'(signed'(lkey[63:32]) + (pl >>> 16));
      kts_pkg::ST_LY: vy <= 32'(signed'(lkey[31:0]) + (pl >>> 16));
      kts_pkg::ST_MUL: prod <= 64'(bind_x) * 64'(vx);
      default: ;
    endcase
  end

  // Output stage with saturation.
  function automatic logic [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fff_ffff;
    if (v < -34'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  logic signed [47:0] ps;
  assign ps = prod[63:16];
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= state == kts_pkg::ST_OUT;
    end
    if (state == kts_pkg::ST_OUT) begin
      result.pose_y <= '0;
      if (kind == kts_pkg::KIND_SCALE) begin
        result.pose_x <= (ps > 48'sd2147483647) ? 32'h7fff_ffff :
                         (ps < -48'sd2147483648) ? 32'h8000_0000 : ps[31:0];
      end else begin
        result.pose_x <= sat(34'(bind_x) + 34'(vx));
        if (kind == kts_pkg::KIND_TRANS) result.pose_y <= sat(34'(bind_y) + 34'(vy));
      end
    end
  end

endmodule
`default_nettype wire
